@@ rtl/wind_direction_vector_average_defines.svh @@
// Assertion macros for the wind direction averaging block.
// Included by the top-level file, which checks its own logic; depends on nothing else.
`ifndef WIND_DIRECTION_VECTOR_AVERAGE_DEFINES_SVH
`define WIND_DIRECTION_VECTOR_AVERAGE_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked assertion with an explicit clock and active-low reset.
`define WDVA_ASSERT_CLK(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("wdva assertion failed");
// Clocked assertion on the block's own clock and reset.
`define WDVA_ASSERT(name, prop) \
  `WDVA_ASSERT_CLK(name, clk_i, rst_ni, prop)
`else
`define WDVA_ASSERT_CLK(name, clk, rstn, prop)
`define WDVA_ASSERT(name, prop)
`endif
`endif

@@ rtl/wdva_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table of the wind
// direction averaging block. Depends on nothing.
package wdva_pkg;

  // Widest corrected angle that a command can carry.
  localparam int unsigned ANGLE_MAX_BITS = 24;

  // Configuration register indexes.
  localparam logic CFG_ANGLE_OFFSET    = 1'b0;
  localparam logic CFG_SPEED_THRESHOLD = 1'b1;

  // Request codes.
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLOSE = 1'b1;

  // Reset value of the speed threshold.
  localparam logic [15:0] THRESHOLD_RESET = 16'd256;

  // CORDIC start gain in Q30, and phase constants at 32 bits per turn.
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic [31:0]        HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0]        QUARTER_TURN = 32'h4000_0000;

  typedef struct packed {
    logic        req_type;
    logic [31:0] reading_time;
    logic [15:0] raw_angle;
    logic [15:0] wind_speed;
  } in_item_t;

  typedef struct packed {
    logic [15:0] mean_angle;
    logic [2:0]  compass_sector;
    logic        direction_valid;
    logic [31:0] period_time;
  } out_item_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    logic                      close;
    logic                      counted;
    logic [31:0]               reading_time;
    logic [ANGLE_MAX_BITS-1:0] corr_angle;
    logic [15:0]               wind_speed;
  } cmd_t;

  // Back end status, seen by the top level.
  typedef struct packed {
    logic busy;
    logic pop;
  } back_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_ITER,
    S_ROUND,
    S_MUL,
    S_ADD,
    S_OUT,
    S_EMIT
  } back_state_e;

  // Arctangent of 2^-i as a fraction of a turn, 32 bits per turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051E;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2F;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2FA;
      5'd15:   r = 32'h0000_517D;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A30;
      5'd19:   r = 32'h0000_0518;
      5'd20:   r = 32'h0000_028C;
      5'd21:   r = 32'h0000_0146;
      5'd22:   r = 32'h0000_00A3;
      5'd23:   r = 32'h0000_0051;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/wdva_front.sv @@
// Front end: holds the configuration registers, accepts input items and
// classifies them into commands. Depends on wdva_pkg.
module wdva_front #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wdva_pkg::in_item_t in_item_i,
  output logic              push_o,
  output wdva_pkg::cmd_t    cmd_o,
  input  logic              q_full_i
);
  import wdva_pkg::*;

  logic [15:0]           angle_offset_q;
  logic [15:0]           speed_threshold_q;
  logic [ANGLE_BITS-1:0] raw_m;
  logic [ANGLE_BITS-1:0] off_m;
  logic [ANGLE_BITS-1:0] corr;

  // Configuration registers; an unknown index cannot occur with one index bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_offset_q    <= '0;
      speed_threshold_q <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ANGLE_OFFSET:    angle_offset_q    <= cfg_wdata_i;
        CFG_SPEED_THRESHOLD: speed_threshold_q <= cfg_wdata_i;
        default:             ;
      endcase
    end
  end

  // Correct the vane angle by the mounting offset, modulo one turn.
  always_comb begin
    raw_m = ANGLE_BITS'(in_item_i.raw_angle);
    off_m = ANGLE_BITS'(angle_offset_q);
    corr  = raw_m - off_m;
  end

  // Classify the item and hand it to the queue.
  always_comb begin
    cmd_o.close        = (in_item_i.req_type == REQ_CLOSE);
    cmd_o.counted      = (in_item_i.wind_speed >= speed_threshold_q);
    cmd_o.reading_time = in_item_i.reading_time;
    cmd_o.corr_angle   = ANGLE_MAX_BITS'(corr);
    cmd_o.wind_speed   = in_item_i.wind_speed;
    in_stall_o         = q_full_i;
    push_o             = in_valid_i && !q_full_i;
  end

endmodule

@@ rtl/wdva_queue.sv @@
// Two-entry command queue between the front and back ends.
// Depends on wdva_pkg for the command type.
module wdva_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wdva_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output wdva_pkg::cmd_t cmd_o
);
  import wdva_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic [1:0] count_d;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

endmodule

@@ rtl/wdva_back.sv @@
// Back end: shared iterative CORDIC for both unit vectors and the azimuth,
// saturating east and north sums, and the result register. Depends on wdva_pkg.
module wdva_back #(
  parameter int unsigned ANGLE_BITS   = 16,
  parameter int unsigned SUM_BITS     = 48,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_valid_i,
  input  wdva_pkg::cmd_t          cmd_i,
  output wdva_pkg::back_status_t  status_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output wdva_pkg::out_item_t     out_item_o
);
  import wdva_pkg::*;

  localparam int unsigned IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);
  localparam int unsigned W = ((SUM_BITS > 35) ? SUM_BITS : 35) + 1;
  localparam logic [31:0] ROUND_BIAS = 32'd1 << (31 - ANGLE_BITS);
  localparam logic [ANGLE_BITS-1:0] SECTOR_BIAS = ANGLE_BITS'(1) << (ANGLE_BITS - 4);
  localparam logic signed [W-1:0] SUM_HI = {{(W - SUM_BITS + 1){1'b0}}, {(SUM_BITS - 1){1'b1}}};
  localparam logic signed [W-1:0] SUM_LO = {{(W - SUM_BITS + 1){1'b1}}, {(SUM_BITS - 1){1'b0}}};

  back_state_e state_q, state_d;
  logic        pop;

  logic signed [33:0]         x_q, y_q, z_q;
  logic [IW-1:0]              i_q;
  logic                       rot_q, flip_q, zero_q;
  logic [SUM_BITS-1:0]        me_q, mn_q;
  logic                       e_neg_q, n_neg_q;
  logic signed [SUM_BITS-1:0] east_q, north_q;
  logic                       any_q;
  logic [31:0]                last_q;
  logic signed [17:0]         ce_q, cn_q;
  logic signed [34:0]         te_q, tn_q;
  logic [15:0]                speed_q;
  out_item_t                  out_q;
  logic                       out_valid_q;

  // CORDIC step and helper signals.
  logic signed [33:0] xs, ys, xn, yn, zn, at, rx, ry;
  logic               dpos;
  logic [31:0]        phase, ph_rot, ph2;
  logic               rflip;
  logic               big, vflip;
  logic signed [33:0] vx, vy;
  logic [31:0]        zsum;
  logic [ANGLE_BITS-1:0] ang, sang;
  logic signed [W-1:0] se, sn, ae, an;

  always_comb begin
    xs   = x_q >>> i_q;
    ys   = y_q >>> i_q;
    at   = $signed({2'b00, atan_turn(5'(i_q))});
    dpos = rot_q ? !z_q[33] : (y_q[33] || (y_q == 34'sd0));
    if (dpos) begin
      xn = x_q - ys;
      yn = y_q + xs;
      zn = z_q - at;
    end else begin
      xn = x_q + ys;
      yn = y_q - xs;
      zn = z_q + at;
    end
  end

  // Rotation set-up: fold the phase into the right half plane.
  always_comb begin
    phase  = 32'(cmd_i.corr_angle[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
    ph_rot = phase + QUARTER_TURN;
    rflip  = ph_rot[31];
    ph2    = rflip ? (phase - HALF_TURN) : phase;
  end

  // Vectoring set-up from the normalised magnitudes.
  always_comb begin
    big   = (me_q[SUM_BITS-1:30] != '0) || (mn_q[SUM_BITS-1:30] != '0);
    vflip = n_neg_q && (mn_q[29:0] != 30'd0);
    vx    = $signed({4'b0000, mn_q[29:0]});
    vy    = (e_neg_q ^ vflip) ? -$signed({4'b0000, me_q[29:0]})
                              : $signed({4'b0000, me_q[29:0]});
  end

  // Rounding of the rotated vector to Q14.
  always_comb begin
    rx = (x_q + 34'sd32768) >>> 16;
    ry = (y_q + 34'sd32768) >>> 16;
  end

  // Azimuth to binary angle and compass sector.
  always_comb begin
    zsum = z_q[31:0] + ROUND_BIAS;
    ang  = zsum[31 -: ANGLE_BITS];
    sang = ang + SECTOR_BIAS;
  end

  // Saturating sums.
  always_comb begin
    se = W'(east_q) + W'(te_q);
    sn = W'(north_q) + W'(tn_q);
    ae = (se > SUM_HI) ? SUM_HI : ((se < SUM_LO) ? SUM_LO : se);
    an = (sn > SUM_HI) ? SUM_HI : ((sn < SUM_LO) ? SUM_LO : sn);
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    pop     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop = 1'b1;
          if (cmd_i.close) begin
            state_d = S_NORM;
          end else if (cmd_i.counted) begin
            state_d = S_ITER;
          end
        end
      end
      S_NORM: begin
        if (!big) begin
          state_d = ((me_q == '0) && (mn_q == '0)) ? S_OUT : S_ITER;
        end
      end
      S_ITER: begin
        if (i_q == LAST_STEP) begin
          state_d = rot_q ? S_ROUND : S_OUT;
        end
      end
      S_ROUND: state_d = S_MUL;
      S_MUL:   state_d = S_ADD;
      S_ADD:   state_d = S_IDLE;
      S_OUT:   state_d = S_EMIT;
      S_EMIT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control and accumulator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      east_q      <= '0;
      north_q     <= '0;
      any_q       <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop && !cmd_i.close) begin
        last_q <= cmd_i.reading_time;
        if (cmd_i.counted) begin
          any_q <= 1'b1;
        end
      end
      if (state_q == S_ADD) begin
        east_q  <= ae[SUM_BITS-1:0];
        north_q <= an[SUM_BITS-1:0];
      end
      if (state_q == S_OUT) begin
        east_q      <= '0;
        north_q     <= '0;
        any_q       <= 1'b0;
        out_valid_q <= 1'b1;
      end
      if ((state_q == S_EMIT) && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // CORDIC and product datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        i_q     <= '0;
        speed_q <= cmd_i.wind_speed;
        rot_q   <= !cmd_i.close;
        flip_q  <= rflip;
        x_q     <= CORDIC_GAIN;
        y_q     <= '0;
        z_q     <= $signed({{2{ph2[31]}}, ph2});
        e_neg_q <= east_q[SUM_BITS-1];
        n_neg_q <= north_q[SUM_BITS-1];
        me_q    <= east_q[SUM_BITS-1] ? (SUM_BITS'(0) - east_q) : east_q;
        mn_q    <= north_q[SUM_BITS-1] ? (SUM_BITS'(0) - north_q) : north_q;
      end
      S_NORM: begin
        zero_q <= (me_q == '0) && (mn_q == '0);
        if (big) begin
          me_q <= me_q >> 1;
          mn_q <= mn_q >> 1;
        end else begin
          x_q <= vx;
          y_q <= vy;
          z_q <= vflip ? $signed({2'b00, HALF_TURN}) : 34'sd0;
        end
      end
      S_ITER: begin
        x_q <= xn;
        y_q <= yn;
        z_q <= zn;
        i_q <= i_q + IW'(1);
      end
      S_ROUND: begin
        cn_q <= flip_q ? -rx[17:0] : rx[17:0];
        ce_q <= flip_q ? -ry[17:0] : ry[17:0];
      end
      S_MUL: begin
        te_q <= ce_q * $signed({1'b0, speed_q});
        tn_q <= cn_q * $signed({1'b0, speed_q});
      end
      S_OUT: begin
        out_q.mean_angle      <= zero_q ? 16'd0 : 16'(ang);
        out_q.compass_sector  <= zero_q ? 3'd0 : sang[ANGLE_BITS-1 -: 3];
        out_q.direction_valid <= any_q;
        out_q.period_time     <= last_q;
      end
      default: ;
    endcase
  end

  assign status_o.busy = (state_q != S_IDLE);
  assign status_o.pop  = pop;
  assign out_valid_o   = out_valid_q;
  assign out_item_o    = out_q;

endmodule

@@ rtl/wind_direction_vector_average.sv @@
// Speed-weighted vector mean of wind direction.
// Counted reading: the back end runs the CORDIC steps, then rounds, multiplies and adds; others return it to idle.
// Close: up to SUM_BITS-30 normalising shifts, the CORDIC steps unless both sums are zero, then the result.
// Rate is set by the single shared CORDIC unit; a 2-entry queue decouples the input.
// Reset clears all control state and sums at once; no clearing pass.
module wind_direction_vector_average #(
  parameter int unsigned ANGLE_BITS   = 16,
  parameter int unsigned SUM_BITS     = 48,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wdva_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wdva_pkg::out_item_t out_item_o
);
  import wdva_pkg::*;
  `include "wind_direction_vector_average_defines.svh"

  logic         push, q_full, q_valid;
  cmd_t         cmd_in, cmd_out;
  back_status_t status;

  // Front end: configuration and classification.
  wdva_front #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .cmd_o      (cmd_in),
    .q_full_i   (q_full)
  );

  // Command queue.
  wdva_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .full_o (q_full),
    .pop_i  (status.pop),
    .valid_o(q_valid),
    .cmd_o  (cmd_out)
  );

  // Back end: CORDIC, sums and result register.
  wdva_back #(
    .ANGLE_BITS  (ANGLE_BITS),
    .SUM_BITS    (SUM_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (cmd_out),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // The back end only takes a command from a non-empty queue.
  `WDVA_ASSERT(a_pop_nonempty, status.pop |-> q_valid)
  // No command is taken while the back end is working on one.
  `WDVA_ASSERT(a_no_pop_busy, status.busy |-> !status.pop)
  // After a result transfer the back end returns to idle first.
  `WDVA_ASSERT(a_out_gap, (out_valid_o && !out_stall_i) |=> !out_valid_o)

endmodule
